// ===== hw/rtl/tci_pkg.sv =====
// ============================================================================
// tci_pkg
// Types and opcode constants shared by the terminal CPU instruction executor.
// ============================================================================
`default_nettype none

package tci_pkg;

    localparam int NUM_REGS  = 32;
    localparam int REG_WIDTH = 12;
    localparam int PC_WIDTH  = 12;

    // opcode groups (high nibble)
    localparam logic [3:0] GRP_ADD   = 4'h0;
    localparam logic [3:0] GRP_JMP   = 4'h1;
    localparam logic [3:0] GRP_LDC   = 4'h2;
    localparam logic [3:0] GRP_MISC3 = 4'h3;
    localparam logic [3:0] GRP_DSZ   = 4'h4;
    localparam logic [3:0] GRP_MISC5 = 4'h5;
    localparam logic [3:0] GRP_IN    = 4'h6;
    localparam logic [3:0] GRP_JMPR  = 4'h7;
    localparam logic [3:0] GRP_TEST  = 4'h8;
    localparam logic [3:0] GRP_AND   = 4'h9;
    localparam logic [3:0] GRP_XOR   = 4'hA;
    localparam logic [3:0] GRP_CMP   = 4'hB;
    localparam logic [3:0] GRP_CTL   = 4'hC;
    localparam logic [3:0] GRP_LDA   = 4'hD;
    localparam logic [3:0] GRP_STA   = 4'hE;
    localparam logic [3:0] GRP_OUT   = 4'hF;

    // single opcodes
    localparam logic [7:0] OP_LDI    = 8'h30;
    localparam logic [7:0] OP_RAL    = 8'h33;
    localparam logic [7:0] OP_RAR    = 8'h35;
    localparam logic [7:0] OP_ISZ    = 8'h50;
    localparam logic [7:0] OP_INC    = 8'h51;
    localparam logic [7:0] OP_ISNZ   = 8'h58;
    localparam logic [7:0] OP_DSZA   = 8'h52;
    localparam logic [7:0] OP_DSNZA  = 8'h5A;
    localparam logic [7:0] OP_DEC    = 8'h5B;
    localparam logic [7:0] OP_CMA    = 8'h5D;
    localparam logic [7:0] OP_CLA    = 8'h5F;
    localparam logic [7:0] OP_LDFF   = 8'h67;
    localparam logic [7:0] OP_CLC0   = 8'hC5;
    localparam logic [7:0] OP_CLC1   = 8'hCD;
    localparam logic [7:0] OP_BANK1  = 8'hFE;
    localparam logic [7:0] OP_BANK0  = 8'hFF;

    // flag test selectors
    localparam logic [2:0] SEL_ACC7  = 3'd5;
    localparam logic [2:0] SEL_CARRY = 3'd6;
    localparam logic [2:0] SEL_NEVER = 3'd7;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] next_byte;
        logic [7:0] io_in;
    } t_in_item;

    typedef struct packed {
        logic [11:0] pc_next;
        logic [7:0]  acc;
        logic        carry;
        logic        zero;
        logic        bank_sel;
        logic        rd_en;
        logic [4:0]  rd_port;
        logic        wr_en;
        logic [4:0]  wr_port;
        logic [7:0]  wr_data;
        logic        bad_opcode;
    } t_out_item;

    typedef struct packed {
        logic [PC_WIDTH-1:0] pc;
        logic [7:0]          acc;
        logic                carry;
        logic                zero;
        logic                bank;
    } t_arch;

    typedef struct packed {
        logic                 en;
        logic [REG_WIDTH-1:0] data;
    } t_rf_wr;

endpackage

`default_nettype wire

// ===== hw/rtl/tci_ram.sv =====
// ============================================================================
// tci_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module tci_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/tci_exec.sv =====
// ============================================================================
// tci_exec
// Instruction decode and execute: next machine state, register write, result.
// ============================================================================
`default_nettype none

module tci_exec (
    input  wire tci_pkg::t_arch    i_st,
    input  wire tci_pkg::t_in_item i_item,
    input  wire logic [11:0]       i_reg,
    output      tci_pkg::t_arch    o_st,
    output      tci_pkg::t_rf_wr   o_wr,
    output      tci_pkg::t_out_item o_res
);

    import tci_pkg::*;

    logic [7:0]  op;
    logic [7:0]  nb;
    logic [3:0]  lo;
    logic [7:0]  rl;
    logic [11:0] p1;
    logic [11:0] pc;
    logic [11:0] skip_pc;
    logic [8:0]  sum9;
    logic [7:0]  dec8;
    logic        skip;
    logic        cond;
    logic [2:0]  sel;

    always_comb begin
        op      = i_item.opcode;
        nb      = i_item.next_byte;
        lo      = op[3:0];
        sel     = op[2:0];
        rl      = i_reg[7:0];
        p1      = i_st.pc + 12'd1;
        pc      = p1;
        skip    = 1'b0;
        cond    = 1'b0;
        sum9    = '0;
        dec8    = '0;
        o_st    = i_st;
        o_wr    = '0;
        o_res   = '0;

        case (op[7:4])
            GRP_ADD: begin
                sum9       = {1'b0, i_st.acc} + {1'b0, rl};
                o_st.acc   = sum9[7:0];
                o_st.carry = sum9[8];
                o_st.zero  = (sum9[7:0] == 8'hFF);
            end
            GRP_JMP: begin
                pc = {lo, 8'h00} + {4'h0, nb} + 12'd1;
            end
            GRP_LDC: begin
                o_wr.en   = 1'b1;
                o_wr.data = {p1[11:8], nb};
                pc        = p1 + 12'd1;
            end
            GRP_MISC3: begin
                if (op == OP_LDI) begin
                    o_st.acc  = nb;
                    o_st.zero = (nb == 8'hFF);
                    pc        = p1 + 12'd1;
                end else if (op == OP_RAL) begin
                    o_st.acc  = {i_st.acc[6:0], i_st.acc[7]};
                    o_st.zero = (i_st.acc == 8'hFF);
                end else if (op == OP_RAR) begin
                    o_st.acc  = {i_st.acc[0], i_st.acc[7:1]};
                    o_st.zero = (i_st.acc == 8'hFF);
                end else begin
                    o_res.bad_opcode = 1'b1;
                end
            end
            GRP_DSZ: begin
                dec8      = rl - 8'd1;
                o_wr.en   = 1'b1;
                o_wr.data = {4'h0, dec8};
                o_st.zero = (dec8 == 8'hFF);
                skip      = (dec8 == 8'hFF);
            end
            GRP_MISC5: begin
                if (op inside {OP_ISZ, OP_INC, OP_ISNZ}) begin
                    sum9       = {1'b0, i_st.acc} + 9'd1;
                    o_st.acc   = sum9[7:0];
                    o_st.carry = sum9[8];
                    o_st.zero  = (sum9[7:0] == 8'hFF);
                    skip       = ((op == OP_ISZ) && (sum9[7:0] == 8'hFF))
                              || ((op == OP_ISNZ) && (sum9[7:0] != 8'hFF));
                end else if (op inside {OP_DSZA, OP_DSNZA, OP_DEC}) begin
                    dec8       = i_st.acc - 8'd1;
                    o_st.carry = (i_st.acc == 8'h00);
                    o_st.acc   = dec8;
                    o_st.zero  = (dec8 == 8'hFF);
                    skip       = ((op == OP_DSZA) && (dec8 == 8'hFF))
                              || ((op == OP_DSNZA) && (dec8 != 8'hFF));
                end else if (op == OP_CMA) begin
                    o_st.acc  = ~i_st.acc;
                    o_st.zero = (i_st.acc == 8'h00);
                end else if (op == OP_CLA) begin
                    o_st.acc  = 8'h00;
                    o_st.zero = 1'b0;
                end else begin
                    o_res.bad_opcode = 1'b1;
                end
            end
            GRP_IN: begin
                if (op == OP_LDFF) begin
                    o_st.acc = 8'hFF;
                end else begin
                    o_res.rd_en   = 1'b1;
                    o_res.rd_port = {1'b0, lo};
                    o_st.acc      = i_item.io_in;
                end
                o_st.zero = (o_st.acc == 8'hFF);
            end
            GRP_JMPR: begin
                pc = i_reg;
            end
            GRP_TEST: begin
                case (sel)
                    SEL_ACC7:  cond = i_st.acc[7];
                    SEL_CARRY: cond = i_st.carry;
                    SEL_NEVER: cond = 1'b0;
                    default: begin
                        o_res.rd_en   = 1'b1;
                        o_res.rd_port = {2'b10, sel};
                        cond          = (i_item.io_in != 8'h00);
                    end
                endcase
                skip = op[3] ? cond : !cond;
            end
            GRP_AND: begin
                o_st.acc  = i_st.acc & rl;
                o_st.zero = ((i_st.acc & rl) == 8'hFF);
            end
            GRP_XOR: begin
                o_st.acc  = i_st.acc ^ rl;
                o_st.zero = ((i_st.acc ^ rl) == 8'hFF);
            end
            GRP_CMP: begin
                if (i_st.acc == rl) begin
                    o_st.zero = 1'b1;
                    skip      = 1'b1;
                end
            end
            GRP_CTL: begin
                if (op == OP_CLC0 || op == OP_CLC1) begin
                    o_st.carry = 1'b0;
                end else begin
                    o_res.wr_en   = 1'b1;
                    o_res.wr_port = {2'b10, sel};
                    o_res.wr_data = {7'h00, op[3]};
                end
            end
            GRP_LDA: begin
                o_st.acc  = rl;
                o_st.zero = (rl == 8'hFF);
            end
            GRP_STA: begin
                o_wr.en   = 1'b1;
                o_wr.data = {p1[11:8], i_st.acc};
            end
            GRP_OUT: begin
                if (op == OP_BANK1) begin
                    o_st.bank = 1'b1;
                end else if (op == OP_BANK0) begin
                    o_st.bank = 1'b0;
                end else begin
                    o_res.wr_en   = 1'b1;
                    o_res.wr_port = {1'b0, lo};
                    o_res.wr_data = i_st.acc;
                end
            end
            default: begin
                o_res.bad_opcode = 1'b1;
            end
        endcase

        skip_pc = p1 + 12'd1;
        if (nb[7:4] inside {4'h1, 4'h2, 4'h3}) begin
            skip_pc = p1 + 12'd2;
        end
        if (skip) begin
            pc = skip_pc;
        end
        o_st.pc = pc;

        o_res.pc_next  = o_st.pc;
        o_res.acc      = o_st.acc;
        o_res.carry    = o_st.carry;
        o_res.zero     = o_st.zero;
        o_res.bank_sel = o_st.bank;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/terminal_cpu_instruction_execute.sv =====
// ============================================================================
// terminal_cpu_instruction_execute
// Executes one terminal CPU instruction per transaction; register file in RAM.
// ============================================================================
//  channel  valid        ready        payload
//  in       i_in_valid   o_in_ready   i_in_data  (opcode, next_byte, io_in)
//  out      o_out_valid  i_out_ready  o_out_data (state after instruction, I/O)
//
//  One instruction per cycle unless the output stalls. Accept edge: register
//  file RAM read at {bank, low nibble}. Execute stage: execute, write back,
//  result register. Same-entry write/read is forwarded.
//  Reset clears PC, accumulator, flags and the 32 register valid bits.
//  A stalled output holds the execute stage; input waits only behind it.
// ============================================================================
`default_nettype none

module terminal_cpu_instruction_execute #(
    parameter int NUM_REGS = tci_pkg::NUM_REGS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire tci_pkg::t_in_item  i_in_data,
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output      tci_pkg::t_out_item o_out_data
);

    import tci_pkg::*;

    localparam int AW = $clog2(NUM_REGS);

    logic                 r_s1_v;
    t_in_item             r_s1_item;
    logic                 r_fwd;
    logic [REG_WIDTH-1:0] r_fwd_data;
    logic                 r_rd_vld;
    logic [NUM_REGS-1:0]  r_vld;
    t_arch                r_st;
    logic                 r_out_v;
    t_out_item            r_out;

    logic                 in_fire;
    logic                 s1_fire;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic                 issue_bank;
    logic [REG_WIDTH-1:0] ram_rdata;
    logic [REG_WIDTH-1:0] reg_q;
    t_arch                ex_st;
    t_rf_wr               ex_wr;
    t_out_item            ex_res;

    assign s1_fire    = r_s1_v && (!r_out_v || i_out_ready);
    assign o_in_ready = !r_s1_v || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    assign we         = s1_fire && ex_wr.en;
    assign waddr      = AW'({r_st.bank, r_s1_item.opcode[3:0]});
    assign issue_bank = s1_fire ? ex_st.bank : r_st.bank;
    assign raddr      = AW'({issue_bank, i_in_data.opcode[3:0]});

    tci_ram #(
        .WIDTH(REG_WIDTH),
        .DEPTH(NUM_REGS)
    ) u_rf (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(ex_wr.data),
        .i_re   (in_fire),
        .i_raddr(raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        if (r_fwd) begin
            reg_q = r_fwd_data;
        end else if (r_rd_vld) begin
            reg_q = ram_rdata;
        end else begin
            reg_q = '0;
        end
    end

    tci_exec u_exec (
        .i_st  (r_st),
        .i_item(r_s1_item),
        .i_reg (reg_q),
        .o_st  (ex_st),
        .o_wr  (ex_wr),
        .o_res (ex_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_st    <= '0;
            r_vld   <= '0;
        end else begin
            if (in_fire) begin
                r_s1_v <= 1'b1;
            end else if (s1_fire) begin
                r_s1_v <= 1'b0;
            end
            if (s1_fire) begin
                r_out_v <= 1'b1;
                r_st    <= ex_st;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (we) begin
                r_vld[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item  <= i_in_data;
            r_fwd      <= we && (waddr == raddr);
            r_fwd_data <= ex_wr.data;
            r_rd_vld   <= r_vld[raddr];
        end
        if (s1_fire) begin
            r_out <= ex_res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && !s1_fire |=> r_s1_v)
        else $error("execute stage dropped a held transaction");

    a_we_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> s1_fire && r_s1_v)
        else $error("register write without an executing instruction");

    a_bad_no_io: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && ex_res.bad_opcode |-> !ex_res.rd_en && !ex_res.wr_en && !ex_wr.en)
        else $error("illegal opcode had a side effect");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_out_v && (r_out.pc_next == r_st.pc))
        else $error("result register and PC disagree");

    a_vld_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> r_vld == '0)
        else $error("register valid bits not cleared by reset");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Checks the terminal CPU instruction executor against a cycle-free
// predictor of the CPU state. A driver streams instructions from a queue; a
// monitor predicts each accepted transaction and compares every result field.
// ============================================================================

module testbench;

    import tci_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int RANDOM_ITEMS = 1150;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    // predicted CPU state
    logic [11:0] cpu_pc = '0;
    logic [7:0]  cpu_acc = '0;
    logic        cpu_carry = 1'b0;
    logic        cpu_zero = 1'b0;
    logic        cpu_bank = 1'b0;
    logic [11:0] cpu_regs [NUM_REGS] = '{default: '0};

    t_in_item  instr_queue [$];
    t_out_item exp_results [$];
    int        drain_marks [$];
    t_out_item want;
    int        total_items = 0;
    int        sent_cnt = 0;
    int        taken_cnt = 0;
    int        err_count = 0;
    int        stall_cycles = 0;
    logic      in_fire = 1'b0;
    logic      rst_done = 1'b0;
    logic      sender_hold;
    logic      quiet;

    logic [7:0] special_ops [16];
    logic [3:0] reg_groups [4];

    terminal_cpu_instruction_execute DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    assign quiet = (sent_cnt >= 400) && (sent_cnt < 650);

    function automatic t_out_item execute_instr(t_in_item it);
        logic [7:0]  op;
        logic [7:0]  nb;
        logic [3:0]  lo;
        logic [4:0]  idx;
        logic [7:0]  rlow;
        logic [7:0]  dec_val;
        logic [11:0] p1;
        logic [11:0] pc;
        logic [8:0]  sum;
        logic        skip;
        logic        cond;
        t_out_item   r;
        op = it.opcode;
        nb = it.next_byte;
        lo = op[3:0];
        idx = {cpu_bank, lo};
        rlow = cpu_regs[idx][7:0];
        p1 = cpu_pc + 12'd1;
        pc = p1;
        skip = 1'b0;
        cond = 1'b0;
        r = '0;
        case (op[7:4])
            GRP_ADD: begin
                sum = {1'b0, cpu_acc} + {1'b0, rlow};
                cpu_acc = sum[7:0];
                cpu_zero = (cpu_acc == 8'hFF);
                cpu_carry = sum[8];
            end
            GRP_JMP: pc = {lo, nb} + 12'd1;
            GRP_LDC: begin
                cpu_regs[idx] = {p1[11:8], nb};
                pc = p1 + 12'd1;
            end
            GRP_MISC3: begin
                if (op == OP_LDI) begin
                    cpu_acc = nb;
                    cpu_zero = (cpu_acc == 8'hFF);
                    pc = p1 + 12'd1;
                end else if (op == OP_RAL) begin
                    cpu_acc = {cpu_acc[6:0], cpu_acc[7]};
                    cpu_zero = (cpu_acc == 8'hFF);
                end else if (op == OP_RAR) begin
                    cpu_acc = {cpu_acc[0], cpu_acc[7:1]};
                    cpu_zero = (cpu_acc == 8'hFF);
                end else begin
                    r.bad_opcode = 1'b1;
                end
            end
            GRP_DSZ: begin
                dec_val = rlow - 8'd1;
                cpu_regs[idx] = {4'h0, dec_val};
                cpu_zero = (dec_val == 8'hFF);
                skip = cpu_zero;
            end
            GRP_MISC5: begin
                if (op == OP_ISZ || op == OP_INC || op == OP_ISNZ) begin
                    sum = {1'b0, cpu_acc} + 9'd1;
                    cpu_acc = sum[7:0];
                    cpu_zero = (cpu_acc == 8'hFF);
                    cpu_carry = sum[8];
                    skip = (op == OP_ISZ && cpu_zero) || (op == OP_ISNZ && !cpu_zero);
                end else if (op == OP_DSZA || op == OP_DSNZA || op == OP_DEC) begin
                    cpu_carry = (cpu_acc == 8'h00);
                    cpu_acc = cpu_acc - 8'd1;
                    cpu_zero = (cpu_acc == 8'hFF);
                    skip = (op == OP_DSZA && cpu_zero) || (op == OP_DSNZA && !cpu_zero);
                end else if (op == OP_CMA) begin
                    cpu_acc = ~cpu_acc;
                    cpu_zero = (cpu_acc == 8'hFF);
                end else if (op == OP_CLA) begin
                    cpu_acc = 8'h00;
                    cpu_zero = 1'b0;
                end else begin
                    r.bad_opcode = 1'b1;
                end
            end
            GRP_IN: begin
                if (op == OP_LDFF) begin
                    cpu_acc = 8'hFF;
                end else begin
                    r.rd_en = 1'b1;
                    r.rd_port = {1'b0, lo};
                    cpu_acc = it.io_in;
                end
                cpu_zero = (cpu_acc == 8'hFF);
            end
            GRP_JMPR: pc = cpu_regs[idx];
            GRP_TEST: begin
                case (op[2:0])
                    SEL_ACC7:  cond = cpu_acc[7];
                    SEL_CARRY: cond = cpu_carry;
                    SEL_NEVER: cond = 1'b0;
                    default: begin
                        r.rd_en = 1'b1;
                        r.rd_port = {2'b10, op[2:0]};
                        cond = (it.io_in != 8'h00);
                    end
                endcase
                skip = op[3] ? cond : !cond;
            end
            GRP_AND: begin
                cpu_acc = cpu_acc & rlow;
                cpu_zero = (cpu_acc == 8'hFF);
            end
            GRP_XOR: begin
                cpu_acc = cpu_acc ^ rlow;
                cpu_zero = (cpu_acc == 8'hFF);
            end
            GRP_CMP: begin
                if (cpu_acc == rlow) begin
                    cpu_zero = 1'b1;
                    skip = 1'b1;
                end
            end
            GRP_CTL: begin
                if (op == OP_CLC0 || op == OP_CLC1) begin
                    cpu_carry = 1'b0;
                end else begin
                    r.wr_en = 1'b1;
                    r.wr_port = {2'b10, op[2:0]};
                    r.wr_data = {7'b0, op[3]};
                end
            end
            GRP_LDA: begin
                cpu_acc = rlow;
                cpu_zero = (cpu_acc == 8'hFF);
            end
            GRP_STA: cpu_regs[idx] = {p1[11:8], cpu_acc};
            default: begin
                if (op == OP_BANK1) begin
                    cpu_bank = 1'b1;
                end else if (op == OP_BANK0) begin
                    cpu_bank = 1'b0;
                end else begin
                    r.wr_en = 1'b1;
                    r.wr_port = {1'b0, lo};
                    r.wr_data = cpu_acc;
                end
            end
        endcase
        // two-byte opcodes are passed over whole
        if (skip) begin
            pc = p1 + 12'd1;
            if (nb[7:4] == GRP_JMP || nb[7:4] == GRP_LDC || nb[7:4] == GRP_MISC3)
                pc = pc + 12'd1;
        end
        cpu_pc = pc;
        r.pc_next = cpu_pc;
        r.acc = cpu_acc;
        r.carry = cpu_carry;
        r.zero = cpu_zero;
        r.bank_sel = cpu_bank;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val) begin
            err_count++;
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, exp_val,
                     act_val);
        end
    endtask

    task automatic add_instr(logic [7:0] op, logic [7:0] nb, logic [7:0] io);
        instr_queue.push_back('{opcode: op, next_byte: nb, io_in: io});
    endtask

    // monitor and predictor
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (exp_results.size() == 0) begin
                    err_count++;
                    $display("%0t unexpected transaction: pc_next %0h acc %0h", $time,
                             out_data.pc_next, out_data.acc);
                end else begin
                    want = exp_results.pop_front();
                    check_field("pc_next", want.pc_next, out_data.pc_next);
                    check_field("acc", want.acc, out_data.acc);
                    check_field("carry", want.carry, out_data.carry);
                    check_field("zero", want.zero, out_data.zero);
                    check_field("bank_sel", want.bank_sel, out_data.bank_sel);
                    check_field("rd_en", want.rd_en, out_data.rd_en);
                    check_field("rd_port", want.rd_port, out_data.rd_port);
                    check_field("wr_en", want.wr_en, out_data.wr_en);
                    check_field("wr_port", want.wr_port, out_data.wr_port);
                    check_field("wr_data", want.wr_data, out_data.wr_data);
                    check_field("bad_opcode", want.bad_opcode, out_data.bad_opcode);
                end
            end
            if (in_valid && in_ready) begin
                exp_results.push_back(execute_instr(in_data));
                taken_cnt++;
            end
            in_fire <= in_valid && in_ready;
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // driver
    always @(negedge clk) begin
        if (rst_done) begin
            out_ready <= quiet || ($urandom_range(0, 99) >= 8);
            if (!in_valid || in_fire) begin
                sender_hold = (drain_marks.size() != 0) && (sent_cnt == drain_marks[0]);
                if (sender_hold && exp_results.size() == 0) begin
                    void'(drain_marks.pop_front());
                    sender_hold = 1'b0;
                end
                if (!sender_hold && instr_queue.size() != 0 &&
                    (quiet || $urandom_range(0, 99) >= 8)) begin
                    in_valid <= 1'b1;
                    in_data <= instr_queue.pop_front();
                    sent_cnt++;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    initial begin
        logic [7:0] op;
        logic [7:0] nb;
        logic [7:0] io;
        special_ops = '{OP_LDI, OP_RAL, OP_RAR, OP_ISZ, OP_INC, OP_ISNZ, OP_DSZA, OP_DSNZA,
                        OP_DEC, OP_CMA, OP_CLA, OP_LDFF, OP_CLC0, OP_CLC1, OP_BANK1,
                        OP_BANK0};
        reg_groups = '{GRP_DSZ, GRP_CMP, GRP_STA, GRP_LDC};

        add_instr(OP_LDI, 8'hFF, 8'h00);
        add_instr({GRP_ADD, 4'h0}, 8'h00, 8'h00);
        add_instr(OP_INC, 8'h00, 8'h00);
        add_instr(OP_DEC, 8'h00, 8'h00);
        add_instr(OP_LDI, 8'h00, 8'h00);
        add_instr(OP_DSZA, 8'h2A, 8'h00);
        add_instr({GRP_STA, 4'h3}, 8'h00, 8'h00);
        add_instr({GRP_DSZ, 4'h0}, 8'h35, 8'h00);
        add_instr({GRP_CMP, 4'h3}, 8'h40, 8'h00);
        add_instr(OP_ISZ, 8'h13, 8'h00);
        add_instr(OP_ISNZ, 8'h01, 8'h00);
        add_instr(OP_DSNZA, 8'hF0, 8'h00);
        add_instr(OP_RAL, 8'h00, 8'h00);
        add_instr(OP_RAR, 8'h00, 8'h00);
        add_instr(OP_CMA, 8'h00, 8'h00);
        add_instr({GRP_AND, 4'h3}, 8'h00, 8'h00);
        add_instr({GRP_XOR, 4'h3}, 8'h00, 8'h00);
        add_instr({GRP_LDA, 4'h3}, 8'h00, 8'h00);
        add_instr(OP_CLA, 8'h00, 8'h00);
        add_instr(OP_LDFF, 8'h00, 8'h00);
        add_instr({GRP_IN, 4'hF}, 8'h00, 8'hFF);
        add_instr({GRP_TEST, 1'b0, 3'd0}, 8'h3C, 8'h00);
        add_instr({GRP_TEST, 1'b1, SEL_ACC7}, 8'h00, 8'h00);
        add_instr({GRP_TEST, 1'b0, SEL_CARRY}, 8'h20, 8'h00);
        add_instr({GRP_TEST, 1'b1, SEL_NEVER}, 8'h00, 8'h00);
        add_instr(OP_CLC1, 8'h00, 8'h00);
        add_instr({GRP_CTL, 4'h8}, 8'h00, 8'h00);
        add_instr(OP_BANK1, 8'h00, 8'h00);
        add_instr({GRP_LDC, 4'h5}, 8'hAB, 8'h00);
        add_instr({GRP_JMPR, 4'h5}, 8'h00, 8'h00);
        add_instr({GRP_OUT, 4'h0}, 8'h00, 8'h00);
        add_instr(OP_BANK0, 8'h00, 8'h00);
        add_instr({GRP_JMP, 4'hF}, 8'hFE, 8'h00);
        add_instr({GRP_LDC, 4'h1}, 8'h77, 8'h00);
        add_instr({GRP_MISC3, 4'h1}, 8'h00, 8'h00);
        add_instr({GRP_MISC5, 4'hE}, 8'h00, 8'h00);
        drain_marks.push_back(instr_queue.size());
        drain_marks.push_back(600);

        repeat (RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       op = special_ops[$urandom_range(0, 15)];
                1, 2:    op = {reg_groups[$urandom_range(0, 3)], 4'($urandom_range(0, 15))};
                default: op = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 9))
                0, 1:    nb = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                2, 3, 4: nb = 8'($urandom_range(0, 63));
                default: nb = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 4))
                0:       io = 8'h00;
                1:       io = 8'hFF;
                default: io = 8'($urandom_range(0, 255));
            endcase
            add_instr(op, nb, io);
        end
        total_items = instr_queue.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        rst_done = 1'b1;

        while (!(taken_cnt == total_items && exp_results.size() == 0) &&
               stall_cycles < STALL_LIMIT)
            @(negedge clk);
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
        end else begin
            repeat (TAIL_CYCLES) @(posedge clk);
            if (err_count == 0)
                $display("TB_OK");
            else
                $display("TB_ERROR");
        end
        $finish;
    end

endmodule
